>>> hdl/dfu_pkg.sv
// Shared types and constants for the DFU download state engine.
`default_nettype none

package dfu_pkg;

    localparam int TRANSFER_SIZE_DEF = 1024;
    localparam int MAX_ITEMS         = 3;

    localparam logic [7:0]  CMD_SET_ADDRESS = 8'h21;
    localparam logic [7:0]  CMD_ERASE_PAGE  = 8'h41;
    localparam logic [23:0] BUSY_POLL_MS    = 24'd100;
    localparam logic [31:0] BLOCK_OFFSET    = 32'd2;
    localparam logic [7:0]  ERR_STATUS      = 8'd10;

    localparam logic [10:0] LEN_STATUS  = 11'd6;
    localparam logic [10:0] LEN_STATE   = 11'd1;
    localparam logic [10:0] LEN_CMDLIST = 11'd3;

    localparam logic [31:0] FLASH_BASE_RST    = 32'h0800_0000;
    localparam logic [10:0] BOOT_SIZE_KB_RST  = 11'd8;
    localparam logic [10:0] FLASH_SIZE_KB_RST = 11'd64;

    localparam logic [1:0] REG_FLASH_BASE    = 2'd0;
    localparam logic [1:0] REG_BOOT_SIZE_KB  = 2'd1;
    localparam logic [1:0] REG_FLASH_SIZE_KB = 2'd2;
    localparam logic [1:0] REG_UPLOAD_ENABLE = 2'd3;

    typedef enum logic [2:0] {
        REQ_DETACH    = 3'd0,
        REQ_DNLOAD    = 3'd1,
        REQ_UPLOAD    = 3'd2,
        REQ_GETSTATUS = 3'd3,
        REQ_CLRSTATUS = 3'd4,
        REQ_GETSTATE  = 3'd5,
        REQ_ABORT     = 3'd6,
        REQ_OTHER     = 3'd7
    } t_req_kind;

    typedef enum logic [2:0] {
        OUT_REPLY       = 3'd0,
        OUT_ERASE       = 3'd1,
        OUT_PROGRAM     = 3'd2,
        OUT_READ        = 3'd3,
        OUT_SYS_RESET   = 3'd4,
        OUT_NOT_HANDLED = 3'd5
    } t_out_kind;

    typedef struct packed {
        t_req_kind   kind;
        logic        blk_zero;
        logic [31:0] offset;
        logic [15:0] plen;
        logic [7:0]  fbyte;
        logic [31:0] fword;
    } t_req;

    typedef struct packed {
        logic [32:0] lo;
        logic [32:0] hi;
        logic        upload_en;
    } t_bounds;

    typedef struct packed {
        t_out_kind   kind;
        logic [10:0] reply_len;
        logic [7:0]  status;
        logic [23:0] poll;
        logic [3:0]  state;
        logic [31:0] addr;
        logic [10:0] count;
        logic        last;
    } t_item;

    typedef struct packed {
        t_item [MAX_ITEMS-1:0] items;
        logic [1:0]            num;
    } t_burst;

endpackage

`default_nettype wire

>>> hdl/dfu_req_engine.sv
// DFU state registers and per-request evaluation into a burst of result items.
`default_nettype none

module dfu_req_engine
    import dfu_pkg::*;
#(
    parameter int TRANSFER_SIZE = TRANSFER_SIZE_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_go,
    input  wire t_req    i_req,
    input  wire t_bounds i_bounds,
    output t_burst       o_burst
);

    localparam int          CntW   = $clog2(TRANSFER_SIZE + 1);
    localparam logic [10:0] TS_LOW = 11'(TRANSFER_SIZE);

    typedef enum logic [3:0] {
        ST_APP_IDLE  = 4'd0,
        ST_APP_DET   = 4'd1,
        ST_IDLE      = 4'd2,
        ST_DN_SYNC   = 4'd3,
        ST_DN_BUSY   = 4'd4,
        ST_DN_IDLE   = 4'd5,
        ST_MAN_SYNC  = 4'd6,
        ST_MAN       = 4'd7,
        ST_MAN_WAIT  = 4'd8,
        ST_UP_IDLE   = 4'd9,
        ST_ERROR     = 4'd10
    } t_fsm_state;

    t_fsm_state        r_state, n_state;
    logic              r_pend_zero, n_pend_zero;
    logic [31:0]       r_pend_offset, n_pend_offset;
    logic [CntW-1:0]   r_pend_len, n_pend_len;
    logic [7:0]        r_pend_cmd, n_pend_cmd;
    logic [31:0]       r_pend_word, n_pend_word;
    logic [31:0]       r_prog_base, n_prog_base;

    logic [31:0]       chk_base;
    logic [CntW-1:0]   chk_cnt;
    logic              in_rng;
    logic [31:0]       up_base;
    logic [31:0]       pend_base;

    assign up_base   = r_prog_base + i_req.offset;
    assign pend_base = r_prog_base + r_pend_offset;

    always_comb begin
        if (i_req.kind == REQ_GETSTATUS) begin
            chk_base = r_pend_zero ? r_pend_word : pend_base;
            chk_cnt  = r_pend_zero ? CntW'(TRANSFER_SIZE) : r_pend_len;
        end else begin
            chk_base = up_base;
            chk_cnt  = CntW'(TRANSFER_SIZE);
        end
    end

    assign in_rng = ({1'b0, chk_base} >= i_bounds.lo)
                 && (({1'b0, chk_base} + 33'(chk_cnt)) <= i_bounds.hi);

    always_comb begin
        t_item blank;
        blank       = '0;
        blank.kind  = OUT_REPLY;

        n_state       = r_state;
        n_pend_zero   = r_pend_zero;
        n_pend_offset = r_pend_offset;
        n_pend_len    = r_pend_len;
        n_pend_cmd    = r_pend_cmd;
        n_pend_word   = r_pend_word;
        n_prog_base   = r_prog_base;

        o_burst          = '0;
        o_burst.items[0] = blank;
        o_burst.items[1] = blank;
        o_burst.items[2] = blank;
        o_burst.num      = 2'd1;

        unique case (i_req.kind)
            REQ_DETACH: begin
                n_state = ST_MAN_SYNC;
                o_burst.items[0].state = 4'(ST_MAN_SYNC);
            end
            REQ_DNLOAD: begin
                if (i_req.plen == 16'd0) begin
                    n_state = ST_MAN_SYNC;
                end else begin
                    n_state       = ST_DN_SYNC;
                    n_pend_zero   = i_req.blk_zero;
                    n_pend_offset = i_req.offset;
                    n_pend_len    = (32'(i_req.plen) > 32'(TRANSFER_SIZE))
                                  ? CntW'(TRANSFER_SIZE) : CntW'(i_req.plen);
                    n_pend_cmd    = i_req.fbyte;
                    n_pend_word   = i_req.fword;
                end
                o_burst.items[0].state = 4'(n_state);
            end
            REQ_UPLOAD: begin
                if (i_req.blk_zero) begin
                    n_state = ST_UP_IDLE;
                    o_burst.items[0].reply_len = LEN_CMDLIST;
                end else if (i_bounds.upload_en && in_rng) begin
                    n_state = ST_UP_IDLE;
                    o_burst.items[0].kind      = OUT_READ;
                    o_burst.items[0].reply_len = TS_LOW;
                    o_burst.items[0].addr      = up_base;
                    o_burst.items[0].count     = TS_LOW;
                end else begin
                    n_state = ST_ERROR;
                end
                o_burst.items[0].state = 4'(n_state);
            end
            REQ_GETSTATUS: begin
                o_burst.items[0].reply_len = LEN_STATUS;
                priority if (r_state == ST_DN_SYNC) begin
                    n_state = ST_DN_IDLE;
                    o_burst.items[0].poll  = BUSY_POLL_MS;
                    o_burst.items[0].state = 4'(ST_DN_BUSY);
                    o_burst.items[1].kind  = OUT_ERASE;
                    o_burst.items[1].state = 4'(ST_DN_IDLE);
                    o_burst.items[2].kind  = OUT_PROGRAM;
                    o_burst.items[2].state = 4'(ST_DN_IDLE);
                    if (r_pend_zero) begin
                        o_burst.items[1].addr = r_pend_word;
                        if (r_pend_cmd == CMD_ERASE_PAGE && in_rng) begin
                            o_burst.num = 2'd2;
                        end else if (r_pend_cmd == CMD_SET_ADDRESS) begin
                            n_prog_base = r_pend_word;
                        end
                    end else begin
                        o_burst.items[1].addr  = pend_base;
                        o_burst.items[2].addr  = pend_base;
                        o_burst.items[2].count = 11'(r_pend_len);
                        if (in_rng) begin
                            o_burst.num = 2'd3;
                        end
                    end
                end else if (r_state == ST_MAN_SYNC || r_state == ST_MAN) begin
                    n_state = ST_MAN;
                    o_burst.items[0].state = 4'(ST_MAN);
                    o_burst.items[1].kind  = OUT_SYS_RESET;
                    o_burst.items[1].state = 4'(ST_MAN);
                    o_burst.num            = 2'd2;
                end else if (r_state == ST_ERROR) begin
                    o_burst.items[0].status = ERR_STATUS;
                    o_burst.items[0].state  = 4'(r_state);
                end else begin
                    o_burst.items[0].state = 4'(r_state);
                end
            end
            REQ_CLRSTATUS: begin
                if (r_state == ST_ERROR) begin
                    n_state = ST_IDLE;
                end
                o_burst.items[0].state = 4'(n_state);
            end
            REQ_GETSTATE: begin
                o_burst.items[0].reply_len = LEN_STATE;
                o_burst.items[0].state     = 4'(r_state);
            end
            REQ_ABORT: begin
                n_state = ST_IDLE;
                o_burst.items[0].state = 4'(ST_IDLE);
            end
            REQ_OTHER: begin
                o_burst.items[0].kind  = OUT_NOT_HANDLED;
                o_burst.items[0].state = 4'(r_state);
            end
            default: begin
                o_burst.items[0].kind  = OUT_NOT_HANDLED;
                o_burst.items[0].state = 4'(r_state);
            end
        endcase

        o_burst.items[0].last = (o_burst.num == 2'd1);
        o_burst.items[1].last = (o_burst.num == 2'd2);
        o_burst.items[2].last = (o_burst.num == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pend_zero   <= 1'b1;
            r_pend_offset <= 32'd0 - (BLOCK_OFFSET * 32'(TRANSFER_SIZE));
            r_pend_len    <= '0;
            r_pend_cmd    <= '0;
            r_pend_word   <= '0;
            r_prog_base   <= '0;
        end else if (i_go) begin
            r_state       <= n_state;
            r_pend_zero   <= n_pend_zero;
            r_pend_offset <= n_pend_offset;
            r_pend_len    <= n_pend_len;
            r_pend_cmd    <= n_pend_cmd;
            r_pend_word   <= n_pend_word;
            r_prog_base   <= n_prog_base;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dfu_result_buf.sv
// Result burst register: holds up to three items and hands them out one at a time on the output.
`default_nettype none

module dfu_result_buf
    import dfu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_burst i_burst,
    input  wire logic   i_stall,
    output logic        o_free,
    output logic        o_valid,
    output t_item       o_item
);

    t_item [MAX_ITEMS-1:0] r_items;
    logic  [1:0]           r_num;
    logic  [1:0]           r_idx;
    logic                  r_busy;
    logic                  take;
    logic                  at_end;

    assign take    = r_busy && !i_stall;
    assign at_end  = (r_idx == (r_num - 2'd1));
    assign o_free  = !r_busy || (take && at_end);
    assign o_valid = r_busy;
    assign o_item  = r_items[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_num  <= 2'd1;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_num  <= i_burst.num;
        end else if (take) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_burst.items;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dfu_download_state_engine.sv
// DFU download state engine top level: request register, configuration and result output.
//
// Usage: one DFU class request enters on the input channel (i_valid / o_stall) with its
// type, block number, length and first payload bytes. Each request gives one to three
// result items on the output channel (o_valid / i_stall): the reply, then erase and program
// commands or a system reset where the request causes them; o_last marks the final item.
// Configuration registers are written over i_cfg_valid / o_cfg_ready (always ready) with
// an index and 32-bit data; the user must write them only while no request is in flight,
// as the block does not enforce it. The first result item of a request passes through the
// request register and then the result register before it is valid on the output.
// The result register hands out one result item per cycle while the receiver does not
// stall, and so sets the pace; a get-status can emit erase and program commands as well.
// A new request is taken while the previous result waits, held in the request register.
// When the receiver stalls, the current item holds and, once the request register is full,
// o_stall rises. Reset clears all control state: DFU state to dfuIDLE, no items pending,
// configuration to its default values.
`default_nettype none

module dfu_download_state_engine
    import dfu_pkg::*;
#(
    parameter int TRANSFER_SIZE = TRANSFER_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [15:0] i_block_value,
    input  wire logic [15:0] i_payload_length,
    input  wire logic [7:0]  i_first_byte,
    input  wire logic [31:0] i_first_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_out_kind,
    output logic [10:0]      o_reply_len,
    output logic [7:0]       o_status_code,
    output logic [23:0]      o_poll_timeout,
    output logic [3:0]       o_state_code,
    output logic [31:0]      o_flash_address,
    output logic [10:0]      o_byte_count,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_flash_base;
    logic [10:0] r_boot_kb;
    logic [10:0] r_flash_kb;
    logic        r_upload_en;
    t_bounds     r_bounds, n_bounds;

    t_req        r_req, n_req;
    logic        r_req_valid;
    logic        go;
    logic        buf_free;
    t_burst      burst;
    t_item       item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_base <= FLASH_BASE_RST;
            r_boot_kb    <= BOOT_SIZE_KB_RST;
            r_flash_kb   <= FLASH_SIZE_KB_RST;
            r_upload_en  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FLASH_BASE:    r_flash_base <= i_cfg_data;
                REG_BOOT_SIZE_KB:  r_boot_kb    <= i_cfg_data[10:0];
                REG_FLASH_SIZE_KB: r_flash_kb   <= i_cfg_data[10:0];
                REG_UPLOAD_ENABLE: r_upload_en  <= i_cfg_data[0];
                default:           r_upload_en  <= r_upload_en;
            endcase
        end
    end

    assign n_bounds.lo        = {1'b0, r_flash_base} + {12'b0, r_boot_kb, 10'b0};
    assign n_bounds.hi        = {1'b0, r_flash_base} + {12'b0, r_flash_kb, 10'b0};
    assign n_bounds.upload_en = r_upload_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.lo        <= {1'b0, FLASH_BASE_RST} + {12'b0, BOOT_SIZE_KB_RST, 10'b0};
            r_bounds.hi        <= {1'b0, FLASH_BASE_RST} + {12'b0, FLASH_SIZE_KB_RST, 10'b0};
            r_bounds.upload_en <= 1'b0;
        end else begin
            r_bounds <= n_bounds;
        end
    end

    assign go      = r_req_valid && buf_free;
    assign o_stall = r_req_valid && !buf_free;

    assign n_req.kind     = t_req_kind'(i_req_type);
    assign n_req.blk_zero = (i_block_value == 16'd0);
    assign n_req.offset   = ({16'b0, i_block_value} - BLOCK_OFFSET) * 32'(TRANSFER_SIZE);
    assign n_req.plen     = i_payload_length;
    assign n_req.fbyte    = i_first_byte;
    assign n_req.fword    = i_first_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_req_valid <= 1'b1;
        end else if (go) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= n_req;
        end
    end

    dfu_req_engine #(
        .TRANSFER_SIZE (TRANSFER_SIZE)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_req    (r_req),
        .i_bounds (r_bounds),
        .o_burst  (burst)
    );

    dfu_result_buf u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go),
        .i_burst (burst),
        .i_stall (i_stall),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .o_item  (item)
    );

    assign o_out_kind      = 3'(item.kind);
    assign o_reply_len     = item.reply_len;
    assign o_status_code   = item.status;
    assign o_poll_timeout  = item.poll;
    assign o_state_code    = item.state;
    assign o_flash_address = item.addr;
    assign o_byte_count    = item.count;
    assign o_last          = item.last;

endmodule

`default_nettype wire
